// ----- hw/rtl/onewire_rom_search_assert.svh -----
// Assertion macros for the 1-Wire ROM search block.
// Uses clk and rst of the including module; empty when SYNTH is defined.
`ifndef ONEWIRE_ROM_SEARCH_ASSERT_SVH
`define ONEWIRE_ROM_SEARCH_ASSERT_SVH
`ifndef SYNTH
`define ORS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("onewire_rom_search: assertion failed");
`define ORS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("onewire_rom_search: assertion failed");
`else
`define ORS_ASSERT(lbl, prop)
`define ORS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/ors_pkg.sv -----
// Types, codes and the CRC-8 step for the 1-Wire ROM search block.
// No dependencies.
package ors_pkg;

  localparam int ROM_BITS = 64;
  localparam int IDX_W    = 7;
  localparam int POS_W    = 6;

  localparam logic [IDX_W-1:0] END_INDEX    = 7'd65;
  localparam logic [IDX_W-1:0] FAMILY_LIMIT = 7'd9;

  localparam logic [1:0] FUNC_FIRST = 2'd0;
  localparam logic [1:0] FUNC_NEXT  = 2'd1;
  localparam logic [1:0] FUNC_BITS  = 2'd2;

  localparam logic [2:0] ST_START   = 3'd0;
  localparam logic [2:0] ST_CONT    = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_END     = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                write_bit;
    logic                write_valid;
    logic [ROM_BITS-1:0] rom_id;
    logic                last_device;
    logic [3:0]          family_discrepancy;
  } rsp_t;

  // Dallas CRC-8, reflected polynomial 0x8C, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 8'h8C;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/ors_if.sv -----
// Channel interfaces of the 1-Wire ROM search block: command and response.
// Depends on nothing; payload widths are fixed.
interface ors_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       presence;
  logic       id_bit;
  logic       cmp_bit;

  modport source (output valid, func, presence, id_bit, cmp_bit, input ready);
  modport sink (input valid, func, presence, id_bit, cmp_bit, output ready);
endinterface

interface ors_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        write_bit;
  logic        write_valid;
  logic [63:0] rom_id;
  logic        last_device;
  logic [3:0]  family_discrepancy;

  modport source (output valid, status, write_bit, write_valid, rom_id, last_device,
                  family_discrepancy, input ready);
  modport sink (input valid, status, write_bit, write_valid, rom_id, last_device,
                family_discrepancy, output ready);
endinterface

// ----- hw/rtl/ors_engine.sv -----
// Search state registers and the per-transaction update of the ROM search.
// Depends on ors_pkg.
module ors_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  ors_pkg::cmd_t cmd,
  output ors_pkg::rsp_t result
);

  logic [ors_pkg::ROM_BITS-1:0] rom_bits, rom_bits_next;
  logic [ors_pkg::IDX_W-1:0]    last_disc, last_disc_next;
  logic [3:0]                   family_disc, family_disc_next;
  logic                         last_dev, last_dev_next;
  logic [ors_pkg::IDX_W-1:0]    bit_index, bit_index_next;
  logic [ors_pkg::IDX_W-1:0]    zero_pos, zero_pos_next;
  logic [7:0]                   crc_acc, crc_acc_next;
  logic                         searching, searching_next;

  logic [ors_pkg::POS_W-1:0] pos;
  logic [ors_pkg::POS_W-1:0] byte_base;
  logic                      dir;
  logic                      found;
  logic [2:0]                status;
  logic                      wbit;
  logic                      wvalid;

  always_comb begin
    rom_bits_next    = rom_bits;
    last_disc_next   = last_disc;
    family_disc_next = family_disc;
    last_dev_next    = last_dev;
    bit_index_next   = bit_index;
    zero_pos_next    = zero_pos;
    crc_acc_next     = crc_acc;
    searching_next   = searching;
    status           = ors_pkg::ST_IGNORED;
    wbit             = 1'b0;
    wvalid           = 1'b0;
    dir              = 1'b0;
    found            = 1'b0;
    pos              = bit_index[ors_pkg::POS_W-1:0] - 6'd1;
    byte_base        = {pos[5:3], 3'b000};

    case (cmd.func)
      ors_pkg::FUNC_FIRST, ors_pkg::FUNC_NEXT: begin
        if (cmd.func == ors_pkg::FUNC_FIRST) begin
          last_disc_next   = '0;
          last_dev_next    = 1'b0;
          family_disc_next = '0;
        end
        bit_index_next = 7'd1;
        zero_pos_next  = '0;
        crc_acc_next   = '0;
        if (last_dev_next || !cmd.presence) begin
          last_disc_next   = '0;
          last_dev_next    = 1'b0;
          family_disc_next = '0;
          searching_next   = 1'b0;
          status           = ors_pkg::ST_END;
        end else begin
          searching_next = 1'b1;
          status         = ors_pkg::ST_START;
        end
      end
      ors_pkg::FUNC_BITS: begin
        if (searching) begin
          if (cmd.id_bit && cmd.cmp_bit) begin
            last_disc_next   = '0;
            last_dev_next    = 1'b0;
            family_disc_next = '0;
            searching_next   = 1'b0;
            status           = ors_pkg::ST_END;
          end else begin
            if (cmd.id_bit != cmd.cmp_bit) begin
              dir = cmd.id_bit;
            end else begin
              if (bit_index < last_disc) begin
                dir = rom_bits[pos];
              end else begin
                dir = (bit_index == last_disc);
              end
              if (!dir) begin
                zero_pos_next = bit_index;
                if (bit_index < ors_pkg::FAMILY_LIMIT) begin
                  family_disc_next = bit_index[3:0];
                end
              end
            end
            rom_bits_next[pos] = dir;
            wbit               = dir;
            wvalid             = 1'b1;
            bit_index_next     = bit_index + 7'd1;
            if (pos[2:0] == 3'd7) begin
              crc_acc_next = ors_pkg::crc8_byte(crc_acc, rom_bits_next[byte_base +: 8]);
            end
            status = ors_pkg::ST_CONT;
            if (bit_index_next >= ors_pkg::END_INDEX) begin
              if (crc_acc_next == 8'd0) begin
                last_disc_next = zero_pos_next;
                if (zero_pos_next == '0) begin
                  last_dev_next = 1'b1;
                end
                if ({3'b000, family_disc_next} == zero_pos_next) begin
                  family_disc_next = '0;
                end
                found = 1'b1;
              end
              if (!found || rom_bits_next[7:0] == 8'd0) begin
                last_disc_next   = '0;
                last_dev_next    = 1'b0;
                family_disc_next = '0;
                found            = 1'b0;
              end
              searching_next = 1'b0;
              status         = found ? ors_pkg::ST_FOUND : ors_pkg::ST_END;
            end
          end
        end
      end
      default: begin
      end
    endcase

    result.status             = status;
    result.write_bit          = wbit;
    result.write_valid        = wvalid;
    result.rom_id             = rom_bits_next;
    result.last_device        = last_dev_next;
    result.family_discrepancy = family_disc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bits    <= '0;
      last_disc   <= '0;
      family_disc <= '0;
      last_dev    <= 1'b0;
      bit_index   <= 7'd1;
      zero_pos    <= '0;
      crc_acc     <= '0;
      searching   <= 1'b0;
    end else if (step) begin
      rom_bits    <= rom_bits_next;
      last_disc   <= last_disc_next;
      family_disc <= family_disc_next;
      last_dev    <= last_dev_next;
      bit_index   <= bit_index_next;
      zero_pos    <= zero_pos_next;
      crc_acc     <= crc_acc_next;
      searching   <= searching_next;
    end
  end

endmodule

// ----- hw/rtl/onewire_rom_search.sv -----
// 1-Wire ROM search engine (binary-tree search ROM), one bus event per transaction.
// Command channel cmd: func selects first start, next start or bit pair; a start
//   carries the presence bit of the bus reset, a bit pair carries id_bit and cmp_bit.
// Response channel rsp: one response per command, in order: status, the direction
//   bit to write (write_valid), the ROM ID built so far, last_device and the
//   family discrepancy.
// Path: a command passes the input register, then the state update and the
//   response register in one pass; a held response keeps it waiting in the
//   input register.
// Throughput: one command per cycle while rsp does not stall (see Stall below).
// Reset (rst, synchronous): all search state cleared, no pass running, both
//   channels empty.
// Stall: a held response stays stable; the input register still takes one more
//   command, then cmd.ready drops until rsp.ready returns.
// Depends on ors_pkg, ors_if, ors_engine, onewire_rom_search_assert.svh.
`include "onewire_rom_search_assert.svh"

module onewire_rom_search (
  input logic       clk,
  input logic       rst,
  ors_cmd_if.sink   cmd,
  ors_rsp_if.source rsp
);

  logic          stage_valid;
  ors_pkg::cmd_t stage;
  logic          fire;
  ors_pkg::rsp_t result;
  ors_pkg::rsp_t rsp_item;
  logic          rsp_valid;
  logic          quiet_status;
  logic          write_flags;

  assign fire      = stage_valid && (!rsp_valid || rsp.ready);
  assign cmd.ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      stage.func     <= cmd.func;
      stage.presence <= cmd.presence;
      stage.id_bit   <= cmd.id_bit;
      stage.cmp_bit  <= cmd.cmp_bit;
    end
  end

  ors_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .cmd    (stage),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (fire) begin
      rsp_item <= result;
    end
  end

  assign rsp.valid              = rsp_valid;
  assign rsp.status             = rsp_item.status;
  assign rsp.write_bit          = rsp_item.write_bit;
  assign rsp.write_valid        = rsp_item.write_valid;
  assign rsp.rom_id             = rsp_item.rom_id;
  assign rsp.last_device        = rsp_item.last_device;
  assign rsp.family_discrepancy = rsp_item.family_discrepancy;

  assign quiet_status = (rsp_item.status == ors_pkg::ST_START) ||
                        (rsp_item.status == ors_pkg::ST_IGNORED);
  assign write_flags  = rsp_item.write_valid || rsp_item.write_bit;

  `ORS_ASSERT_NEXT(a_accept_fills_stage, cmd.valid && cmd.ready, stage_valid)
  `ORS_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_valid)
  `ORS_ASSERT(a_write_only_on_bits, !(rsp_valid && quiet_status && write_flags))

endmodule
